FILE: sv/bsa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// banker's safety allocator. No dependencies.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int PROC_W        = $clog2(MAX_PROCESSES);
    localparam int RES_W         = $clog2(MAX_RESOURCES);
    localparam int ENTRY_AW      = PROC_W + RES_W;
    localparam int ENTRIES       = MAX_PROCESSES * MAX_RESOURCES;
    localparam int WORK_W        = 13;
    localparam logic [WORK_W-1:0] WORK_MAX = '1;

    // Function codes of an input item.
    localparam logic [2:0] FN_WR_ALLOC = 3'd0;
    localparam logic [2:0] FN_WR_MAX   = 3'd1;
    localparam logic [2:0] FN_WR_AVAIL = 3'd2;
    localparam logic [2:0] FN_STAGE    = 3'd3;
    localparam logic [2:0] FN_CHECK    = 3'd4;
    localparam logic [2:0] FN_REQUEST  = 3'd5;

    // Status codes of a result item.
    localparam logic [2:0] ST_SAFE       = 3'd0;
    localparam logic [2:0] ST_UNSAFE     = 3'd1;
    localparam logic [2:0] ST_GRANTED    = 3'd2;
    localparam logic [2:0] ST_OVER_NEED  = 3'd3;
    localparam logic [2:0] ST_OVER_AVAIL = 3'd4;
    localparam logic [2:0] ST_ROLLED     = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;
        logic       clr_wr;
        logic       wr_alloc;
        logic       wr_need;
        logic       wr_avail;
        logic       wr_stage;
        logic       chk_init;
        logic       p_inc;
        logic       scan_start;
        logic       scan_req;
        logic       commit;
        logic       apply_wr;
        logic       rollback_wr;
        logic       out_order;
        logic       out_code;
        logic [2:0] code;
        logic       code_proc_zero;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic fits;
        logic p_end;
        logic p_fin;
        logic n_last;
        logic over_need;
        logic over_avail;
        logic proc_bad;
        logic wr_last;
        logic res_last;
    } dp_sts_t;

endpackage

FILE: sv/bsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/bsa_datapath.sv
// Datapath of the banker's safety allocator: tables, scratch counts, scan
// counters and the result register. Depends on bsa_pkg and bsa_ram.
`timescale 1ns / 1ps

module bsa_datapath
    import bsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [4:0]          process_count,
    input  logic [3:0]          resource_count,
    input  logic [PROC_W-1:0]   in_process,
    input  logic [RES_W-1:0]    in_resource,
    input  logic [7:0]          in_amount,
    output logic [2:0]          res_status,
    output logic [PROC_W-1:0]   res_process,
    output logic                res_last
);

    // Latched item.
    logic [PROC_W-1:0] it_proc_reg;
    logic [RES_W-1:0]  it_res_reg;
    logic [7:0]        amt_reg;

    // Small tables and scratch.
    logic [WORK_W-1:0] avail_reg [MAX_RESOURCES];
    logic [7:0]        stage_reg [MAX_RESOURCES];
    logic [WORK_W-1:0] work_reg  [MAX_RESOURCES];
    logic [WORK_W-1:0] tmp_reg   [MAX_RESOURCES];
    logic [7:0]        save_alloc_reg [MAX_RESOURCES];
    logic [7:0]        save_need_reg  [MAX_RESOURCES];
    logic [WORK_W-1:0] save_avail_reg [MAX_RESOURCES];
    logic [PROC_W-1:0] order_reg [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] finished_reg;

    // Scan control.
    logic [PROC_W:0]   p_reg;
    logic [RES_W-1:0]  r_reg;
    logic              issuing_reg;
    logic              ev_vld_reg;
    logic [RES_W-1:0]  ev_r_reg;
    logic              mode_req_reg;
    logic              fits_reg;
    logic              xn_reg;
    logic              xa_reg;
    logic [PROC_W:0]   n_reg;
    logic [RES_W-1:0]  wr_r_reg;
    logic [ENTRY_AW-1:0] clr_cnt_reg;
    logic [PROC_W-1:0] out_k_reg;

    logic [2:0]        res_status_reg;
    logic [PROC_W-1:0] res_proc_reg;
    logic              res_last_reg;

    // RAM ports.
    logic                alloc_we, need_we;
    logic [ENTRY_AW-1:0] alloc_waddr, need_waddr, raddr;
    logic [7:0]          alloc_wdata, need_wdata, alloc_rd, need_rd;

    logic                r_last, ev_last, wr_last, k_last;
    logic [ENTRY_AW-1:0] req_addr;
    logic [8:0]          grant_sum;
    logic [WORK_W:0]     work_sum;
    logic [WORK_W-1:0]   work_sat;
    logic [7:0]          ev_req;
    logic [WORK_W-1:0]   ev_work, ev_avail;

    assign r_last  = ({1'b0, r_reg} + 4'd1) == resource_count;
    assign ev_last = ({1'b0, ev_r_reg} + 4'd1) == resource_count;
    assign wr_last = ({1'b0, wr_r_reg} + 4'd1) == resource_count;
    assign k_last  = ({1'b0, out_k_reg} + 5'd1) == process_count;

    assign req_addr  = {it_proc_reg, wr_r_reg};
    assign raddr     = issuing_reg ? {p_reg[PROC_W-1:0], r_reg} : {it_proc_reg, it_res_reg};
    assign ev_req    = stage_reg[ev_r_reg];
    assign ev_work   = work_reg[ev_r_reg];
    assign ev_avail  = avail_reg[ev_r_reg];
    assign grant_sum = {1'b0, save_alloc_reg[wr_r_reg]} + {1'b0, stage_reg[wr_r_reg]};
    assign work_sum  = {1'b0, ev_work} + {{(WORK_W-7){1'b0}}, alloc_rd};
    assign work_sat  = work_sum[WORK_W] ? WORK_MAX : work_sum[WORK_W-1:0];

    // Write port selection for the allocation table.
    always_comb begin
        alloc_we    = 1'b0;
        alloc_waddr = {it_proc_reg, it_res_reg};
        alloc_wdata = amt_reg;
        if (cmd.clr_wr) begin
            alloc_we    = 1'b1;
            alloc_waddr = clr_cnt_reg;
            alloc_wdata = '0;
        end else if (cmd.wr_alloc) begin
            alloc_we = 1'b1;
        end else if (cmd.apply_wr) begin
            alloc_we    = 1'b1;
            alloc_waddr = req_addr;
            alloc_wdata = grant_sum[8] ? 8'hff : grant_sum[7:0];
        end else if (cmd.rollback_wr) begin
            alloc_we    = 1'b1;
            alloc_waddr = req_addr;
            alloc_wdata = save_alloc_reg[wr_r_reg];
        end
    end

    // Write port selection for the need table.
    always_comb begin
        need_we    = 1'b0;
        need_waddr = {it_proc_reg, it_res_reg};
        need_wdata = (amt_reg > alloc_rd) ? amt_reg - alloc_rd : 8'd0;
        if (cmd.clr_wr) begin
            need_we    = 1'b1;
            need_waddr = clr_cnt_reg;
            need_wdata = '0;
        end else if (cmd.wr_need) begin
            need_we = 1'b1;
        end else if (cmd.apply_wr) begin
            need_we    = 1'b1;
            need_waddr = req_addr;
            need_wdata = save_need_reg[wr_r_reg] - stage_reg[wr_r_reg];
        end else if (cmd.rollback_wr) begin
            need_we    = 1'b1;
            need_waddr = req_addr;
            need_wdata = save_need_reg[wr_r_reg];
        end
    end

    bsa_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_alloc_ram (
        .aclk  (aclk),
        .we    (alloc_we),
        .waddr (alloc_waddr),
        .wdata (alloc_wdata),
        .raddr (raddr),
        .rdata (alloc_rd)
    );

    bsa_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_need_ram (
        .aclk  (aclk),
        .we    (need_we),
        .waddr (need_waddr),
        .wdata (need_wdata),
        .raddr (raddr),
        .rdata (need_rd)
    );

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            it_proc_reg <= in_process;
            it_res_reg  <= in_resource;
            amt_reg     <= in_amount;
        end
    end

    // Available counts and staged request, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                avail_reg[i] <= '0;
                stage_reg[i] <= '0;
            end
        end else begin
            if (cmd.wr_avail) begin
                avail_reg[it_res_reg] <= {{(WORK_W-8){1'b0}}, amt_reg};
            end
            if (cmd.wr_stage) begin
                stage_reg[it_res_reg] <= amt_reg;
            end
            if (cmd.apply_wr) begin
                avail_reg[wr_r_reg] <= avail_reg[wr_r_reg]
                                       - {{(WORK_W-8){1'b0}}, stage_reg[wr_r_reg]};
            end
            if (cmd.rollback_wr) begin
                avail_reg[wr_r_reg] <= save_avail_reg[wr_r_reg];
            end
        end
    end

    // Scratch evaluation: tentative work sums and request snapshots.
    always_ff @(posedge aclk) begin
        if (cmd.chk_init) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                work_reg[i] <= avail_reg[i];
            end
        end else if (cmd.commit) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                if (i < int'(resource_count)) begin
                    work_reg[i] <= tmp_reg[i];
                end
            end
        end
        if (ev_vld_reg) begin
            if (mode_req_reg) begin
                save_alloc_reg[ev_r_reg] <= alloc_rd;
                save_need_reg[ev_r_reg]  <= need_rd;
                save_avail_reg[ev_r_reg] <= ev_avail;
            end else begin
                tmp_reg[ev_r_reg] <= work_sat;
            end
        end
        if (cmd.commit) begin
            order_reg[n_reg[PROC_W-1:0]] <= p_reg[PROC_W-1:0];
        end
    end

    // Scan, pass and loop counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg        <= '0;
            r_reg        <= '0;
            issuing_reg  <= 1'b0;
            ev_vld_reg   <= 1'b0;
            ev_r_reg     <= '0;
            mode_req_reg <= 1'b0;
            fits_reg     <= 1'b0;
            xn_reg       <= 1'b0;
            xa_reg       <= 1'b0;
            n_reg        <= '0;
            wr_r_reg     <= '0;
            clr_cnt_reg  <= '0;
            out_k_reg    <= '0;
            finished_reg <= '0;
        end else begin
            ev_vld_reg <= issuing_reg;
            ev_r_reg   <= r_reg;
            if (issuing_reg) begin
                r_reg <= r_last ? '0 : r_reg + 1'b1;
                if (r_last) begin
                    issuing_reg <= 1'b0;
                end
            end
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.chk_init) begin
                p_reg        <= '0;
                n_reg        <= '0;
                finished_reg <= '0;
            end
            if (cmd.p_inc) begin
                p_reg <= p_reg + 1'b1;
            end
            if (cmd.scan_start) begin
                issuing_reg  <= 1'b1;
                r_reg        <= '0;
                mode_req_reg <= cmd.scan_req;
                fits_reg     <= 1'b1;
                xn_reg       <= 1'b0;
                xa_reg       <= 1'b0;
                if (cmd.scan_req) begin
                    p_reg <= {1'b0, it_proc_reg};
                end
            end else if (ev_vld_reg) begin
                if (mode_req_reg) begin
                    if (ev_req > need_rd) begin
                        xn_reg <= 1'b1;
                    end
                    if ({{(WORK_W-8){1'b0}}, ev_req} > ev_avail) begin
                        xa_reg <= 1'b1;
                    end
                end else if ({{(WORK_W-8){1'b0}}, need_rd} > ev_work) begin
                    fits_reg <= 1'b0;
                end
            end
            if (cmd.commit) begin
                finished_reg[p_reg[PROC_W-1:0]] <= 1'b1;
                n_reg <= n_reg + 1'b1;
                p_reg <= '0;
            end
            if (cmd.apply_wr || cmd.rollback_wr) begin
                wr_r_reg <= wr_last ? '0 : wr_r_reg + 1'b1;
            end
            if (cmd.out_order) begin
                out_k_reg <= k_last ? '0 : out_k_reg + 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.out_order) begin
            res_status_reg <= ST_SAFE;
            res_proc_reg   <= order_reg[out_k_reg];
            res_last_reg   <= k_last;
        end else if (cmd.out_code) begin
            res_status_reg <= cmd.code;
            res_proc_reg   <= cmd.code_proc_zero ? '0 : it_proc_reg;
            res_last_reg   <= 1'b1;
        end
    end

    assign res_status  = res_status_reg;
    assign res_process = res_proc_reg;
    assign res_last    = res_last_reg;

    // Status toward the controller.
    assign sts.clr_last   = &clr_cnt_reg;
    assign sts.scan_done  = ev_vld_reg && ev_last;
    assign sts.fits       = fits_reg;
    assign sts.p_end      = p_reg >= process_count;
    assign sts.p_fin      = finished_reg[p_reg[PROC_W-1:0]];
    assign sts.n_last     = (n_reg + 5'd1) == process_count;
    assign sts.over_need  = xn_reg;
    assign sts.over_avail = xa_reg;
    assign sts.proc_bad   = {1'b0, it_proc_reg} >= process_count;
    assign sts.wr_last    = wr_last;
    assign sts.res_last   = res_last_reg;

endmodule

FILE: sv/bsa_ctrl.sv
// Controller state machine of the banker's safety allocator.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [2:0] in_func,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    typedef enum logic [17:0] {
        S_CLEAR      = 18'h00001,
        S_IDLE       = 18'h00002,
        S_W_ALLOC    = 18'h00004,
        S_MAX_RD     = 18'h00008,
        S_MAX_WR     = 18'h00010,
        S_W_AVAIL    = 18'h00020,
        S_W_STAGE    = 18'h00040,
        S_CHK_INIT   = 18'h00080,
        S_CHK_SEEK   = 18'h00100,
        S_CHK_SCAN   = 18'h00200,
        S_CHK_DECIDE = 18'h00400,
        S_REQ_START  = 18'h00800,
        S_REQ_SCAN   = 18'h01000,
        S_REQ_DECIDE = 18'h02000,
        S_REQ_APPLY  = 18'h04000,
        S_ROLLBACK   = 18'h08000,
        S_OUT_LOAD   = 18'h10000,
        S_OUT_WAIT   = 18'h20000
    } state_t;

    state_t state_reg, state_next;
    logic   req_mode_reg;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT_WAIT);
    assign accept   = s_tvalid && s_tready;

    // State register; also remembers whether the running check belongs to a request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            req_mode_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                req_mode_reg <= (in_func == FN_REQUEST);
            end
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.latch  = accept;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    case (in_func)
                        FN_WR_ALLOC: state_next = S_W_ALLOC;
                        FN_WR_MAX:   state_next = S_MAX_RD;
                        FN_WR_AVAIL: state_next = S_W_AVAIL;
                        FN_STAGE:    state_next = S_W_STAGE;
                        FN_CHECK:    state_next = S_CHK_INIT;
                        FN_REQUEST:  state_next = S_REQ_START;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_W_ALLOC: begin
                cmd.wr_alloc = 1'b1;
                state_next   = S_IDLE;
            end
            S_MAX_RD: begin
                state_next = S_MAX_WR;
            end
            S_MAX_WR: begin
                cmd.wr_need = 1'b1;
                state_next  = S_IDLE;
            end
            S_W_AVAIL: begin
                cmd.wr_avail = 1'b1;
                state_next   = S_IDLE;
            end
            S_W_STAGE: begin
                cmd.wr_stage = 1'b1;
                state_next   = S_IDLE;
            end
            S_CHK_INIT: begin
                cmd.chk_init = 1'b1;
                state_next   = S_CHK_SEEK;
            end
            S_CHK_SEEK: begin
                if (sts.p_end) begin
                    if (req_mode_reg) begin
                        state_next = S_ROLLBACK;
                    end else begin
                        cmd.out_code       = 1'b1;
                        cmd.code           = ST_UNSAFE;
                        cmd.code_proc_zero = 1'b1;
                        state_next         = S_OUT_WAIT;
                    end
                end else if (sts.p_fin) begin
                    cmd.p_inc = 1'b1;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_CHK_SCAN;
                end
            end
            S_CHK_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_CHK_DECIDE;
                end
            end
            S_CHK_DECIDE: begin
                if (sts.fits) begin
                    cmd.commit = 1'b1;
                    if (!sts.n_last) begin
                        state_next = S_CHK_SEEK;
                    end else if (req_mode_reg) begin
                        cmd.out_code = 1'b1;
                        cmd.code     = ST_GRANTED;
                        state_next   = S_OUT_WAIT;
                    end else begin
                        state_next = S_OUT_LOAD;
                    end
                end else begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_CHK_SEEK;
                end
            end
            S_REQ_START: begin
                if (sts.proc_bad) begin
                    cmd.out_code = 1'b1;
                    cmd.code     = ST_OVER_NEED;
                    state_next   = S_OUT_WAIT;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_req   = 1'b1;
                    state_next     = S_REQ_SCAN;
                end
            end
            S_REQ_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_REQ_DECIDE;
                end
            end
            S_REQ_DECIDE: begin
                if (sts.over_need) begin
                    cmd.out_code = 1'b1;
                    cmd.code     = ST_OVER_NEED;
                    state_next   = S_OUT_WAIT;
                end else if (sts.over_avail) begin
                    cmd.out_code = 1'b1;
                    cmd.code     = ST_OVER_AVAIL;
                    state_next   = S_OUT_WAIT;
                end else begin
                    state_next = S_REQ_APPLY;
                end
            end
            S_REQ_APPLY: begin
                cmd.apply_wr = 1'b1;
                if (sts.wr_last) begin
                    state_next = S_CHK_INIT;
                end
            end
            S_ROLLBACK: begin
                cmd.rollback_wr = 1'b1;
                if (sts.wr_last) begin
                    cmd.out_code = 1'b1;
                    cmd.code     = ST_ROLLED;
                    state_next   = S_OUT_WAIT;
                end
            end
            S_OUT_LOAD: begin
                cmd.out_order = 1'b1;
                state_next    = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_tready) begin
                    state_next = sts.res_last ? S_IDLE : S_OUT_LOAD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bankers_safety_allocator.sv
// Banker's algorithm deadlock-avoidance allocator.
// Input stream (s_*) carries one item per handshake: table writes, request
// staging, a safety check, or a request submit. Result stream (m_*) carries
// status items; a safety check gives one item per process in safe order with
// tlast on the final one, or one unsafe item; a request gives one item.
// Table writes give no result. A safety check scans the tables, reading one
// need/allocation entry per cycle, and then sends its result items. A
// request first checks its staged amounts against need and availability,
// updates the tables and runs a safety check; it restores the tables when
// it is rolled back.
// One item is in work at a time; s_tready is high only when idle. When the
// receiver stalls, the result is held in the output register until taken.
// After reset a clearing pass zeroes the 128-entry allocation and need
// tables; no item is accepted until it ends. Configuration is written over
// the APB port and must only change while the block is idle.
// Depends on bsa_pkg, bsa_ctrl, bsa_datapath and bsa_ram.
`timescale 1ns / 1ps

module bankers_safety_allocator
    import bsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // process[3:0], resource[6:4], amount[14:7], zero[15]
    input  logic [2:0]  s_tuser,   // func[2:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // process_res[3:0], zero[7:4]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast    // last
);

    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

    logic [4:0] process_count_reg;
    logic [3:0] resource_count_reg;
    logic       cfg_wr;
    logic [4:0] pc_wr;
    logic [3:0] rc_wr;
    logic [2:0] res_status;
    logic [3:0] res_process;
    logic       res_last;
    dp_cmd_t    cmd;
    dp_sts_t    sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Counts are held within their legal ranges.
    always_comb begin
        pc_wr = pwdata[4:0];
        if (pc_wr == 5'd0) begin
            pc_wr = 5'd1;
        end else if (pc_wr > 5'(MAX_PROCESSES)) begin
            pc_wr = 5'(MAX_PROCESSES);
        end
        rc_wr = pwdata[3:0];
        if (rc_wr == 4'd0) begin
            rc_wr = 4'd1;
        end else if (rc_wr > 4'(MAX_RESOURCES)) begin
            rc_wr = 4'(MAX_RESOURCES);
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            process_count_reg  <= 5'(MAX_PROCESSES);
            resource_count_reg <= 4'(MAX_RESOURCES);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PROCESS_COUNT:  process_count_reg  <= pc_wr;
                REG_RESOURCE_COUNT: resource_count_reg <= rc_wr;
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            REG_PROCESS_COUNT:  prdata = {27'd0, process_count_reg};
            REG_RESOURCE_COUNT: prdata = {28'd0, resource_count_reg};
            default:            prdata = '0;
        endcase
    end

    bsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_func  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bsa_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .process_count  (process_count_reg),
        .resource_count (resource_count_reg),
        .in_process     (s_tdata[3:0]),
        .in_resource    (s_tdata[6:4]),
        .in_amount      (s_tdata[14:7]),
        .res_status     (res_status),
        .res_process    (res_process),
        .res_last       (res_last)
    );

    assign m_tdata = {4'd0, res_process};
    assign m_tuser = res_status;
    assign m_tlast = res_last;

endmodule
